>>> hdl/kbrg_pkg.sv
// Package for the keyed block random generator.
// Holds state codes, command codes, mixing constants and the rotate helper.
// No dependencies.
package kbrg_pkg;

    localparam logic [31:0] C_KEY_MUL = 32'h06a0dd9b;
    localparam logic [31:0] C_KEY_XOR = 32'h6c26fc92;
    localparam logic [31:0] C_FMIX1   = 32'h85ebca6b;
    localparam logic [31:0] C_FMIX2   = 32'hc2b2ae35;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    localparam logic [7:0] IDX_LAST = 8'hFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KT0,
        ST_KT1,
        ST_KT2,
        ST_KT3,
        ST_FILL_MUL,
        ST_FILL_WR,
        ST_FOLD,
        ST_FOLD_END,
        ST_APPLY,
        ST_APPLY_END,
        ST_NX1,
        ST_NX2,
        ST_NX3,
        ST_NOWORD
    } state_t;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] r);
        logic [63:0] t;
        t = {v, v} << r;
        return t[63:32];
    endfunction

endpackage

>>> hdl/kbrg_req_if.sv
// Request channel of the keyed block random generator.
// Carries command, key and block length with a valid/ready handshake.
interface kbrg_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] key;
    logic [7:0]  block_length;

    modport source (output valid, output command, output key, output block_length,
                    input ready);
    modport sink   (input valid, input command, input key, input block_length,
                    output ready);
endinterface

>>> hdl/kbrg_rsp_if.sv
// Result channel of the keyed block random generator.
// Carries word, last and no_word with a valid/ready handshake.
interface kbrg_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] word;
    logic        last;
    logic        no_word;

    modport source (output valid, output word, output last, output no_word,
                    input ready);
    modport sink   (input valid, input word, input last, input no_word,
                    output ready);
endinterface

>>> hdl/keyed_block_random_generator.sv
// Keyed block random generator, top level. Uses kbrg_pkg, kbrg_req_if, kbrg_rsp_if.
// Next request: states NX1, NX2, NX3 (NOWORD if no word is left) register the result, waiting
// there while the output is busy; a new request is taken only back in idle, paced by two reads
// of the single-read-port table plus the mix. Start request: key hash, then each entry through
// the shared multiplier (baseline mode); premix mode adds the fold and apply sweeps.
// Reset (rst_n, async, active low) clears control state; table undefined until a start.
module keyed_block_random_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_data,
    kbrg_req_if.sink    req,
    kbrg_rsp_if.source  rsp
);
    import kbrg_pkg::*;

    state_t      state_reg;
    state_t      state_next;

    logic        mode_reg;
    logic        start_mode_reg;
    logic [31:0] key_reg;
    logic [7:0]  cnt_reg;
    logic [31:0] prod_reg;
    logic [31:0] kt_reg;
    logic [31:0] nc_reg;
    logic [31:0] hacc_reg;
    logic [31:0] kacc_reg;
    logic [31:0] h_reg [0:7];
    logic        rd_pend_reg;
    logic [7:0]  rd_idx_reg;
    logic [31:0] rdata_reg;
    logic [31:0] t6_reg;
    logic [31:0] o_reg;
    logic [31:0] mixk_reg;
    logic [31:0] accum_reg;
    logic [7:0]  d_reg;
    logic [7:0]  step_reg;
    logic [7:0]  remain_reg;
    logic [31:0] word_reg;
    logic        last_reg;
    logic        noword_reg;
    logic        rsp_valid_reg;

    logic [31:0] table_mem [0:255];

    logic        mem_we;
    logic [7:0]  mem_waddr;
    logic [31:0] mem_wdata;
    logic [7:0]  mem_raddr;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] mul_p;
    logic        req_ready;
    logic        req_acc;
    logic        out_free;
    logic        out_load;

    logic [31:0] kt1_h;
    logic [31:0] kt1_m;
    logic [31:0] kt2_m;
    logic [31:0] kt3_m;
    logic [31:0] fold_x;
    logic [31:0] o_c;
    logic [31:0] a_new;
    logic [31:0] b_c;
    logic [31:0] w_c;

    assign kt1_h  = prod_reg ^ C_KEY_XOR;
    assign kt1_m  = kt1_h ^ (kt1_h >> 16);
    assign kt2_m  = prod_reg ^ (prod_reg >> 13);
    assign kt3_m  = prod_reg ^ (prod_reg >> 16);
    assign fold_x = hacc_reg ^ rdata_reg;
    assign o_c    = (t6_reg << 6) ^ (rdata_reg << 7);
    assign a_new  = ({24'd0, d_reg} ^ o_c) ^ (mixk_reg + accum_reg);
    assign b_c    = (mixk_reg + accum_reg) ^ (o_reg + {24'd0, d_reg});
    assign w_c    = rotl32((accum_reg >> 13) ^ accum_reg, b_c[4:0]);
    assign mul_p  = mul_a * mul_b;

    assign req.ready   = req_ready;
    assign req_acc     = req.valid && req_ready;
    assign out_free    = !rsp_valid_reg || rsp.ready;
    assign out_load    = ((state_reg == ST_NX3) || (state_reg == ST_NOWORD)) && out_free;

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.word    = word_reg;
    assign rsp.last    = last_reg;
    assign rsp.no_word = noword_reg;

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = rd_idx_reg;
        mem_wdata  = rdata_reg ^ h_reg[rd_idx_reg[7:5]];
        mem_raddr  = cnt_reg;
        mul_a      = 32'd0;
        mul_b      = 32'd0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                mem_raddr = step_reg + 8'd6;
                if (req.valid)
                begin
                    if (req.command == CMD_START)
                        state_next = ST_KT0;
                    else if (remain_reg == 8'd0)
                        state_next = ST_NOWORD;
                    else
                        state_next = ST_NX1;
                end
            end
            ST_KT0:
            begin
                mul_a      = key_reg;
                mul_b      = C_KEY_MUL;
                state_next = ST_KT1;
            end
            ST_KT1:
            begin
                mul_a      = kt1_m;
                mul_b      = C_FMIX1;
                state_next = ST_KT2;
            end
            ST_KT2:
            begin
                mul_a      = kt2_m;
                mul_b      = C_FMIX2;
                state_next = ST_KT3;
            end
            ST_KT3:
            begin
                state_next = ST_FILL_MUL;
            end
            ST_FILL_MUL:
            begin
                mul_a      = nc_reg;
                mul_b      = kt_reg;
                state_next = ST_FILL_WR;
            end
            ST_FILL_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = rotl32(prod_reg, key_reg[4:0] ^ cnt_reg[4:0]);
                if (cnt_reg == IDX_LAST)
                    state_next = start_mode_reg ? ST_FOLD : ST_IDLE;
                else
                    state_next = ST_FILL_MUL;
            end
            ST_FOLD:
            begin
                if (cnt_reg == IDX_LAST)
                    state_next = ST_FOLD_END;
            end
            ST_FOLD_END:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                mem_we = rd_pend_reg;
                if (cnt_reg == IDX_LAST)
                    state_next = ST_APPLY_END;
            end
            ST_APPLY_END:
            begin
                mem_we     = rd_pend_reg;
                state_next = ST_IDLE;
            end
            ST_NX1:
            begin
                mem_raddr  = step_reg + 8'd7;
                state_next = ST_NX2;
            end
            ST_NX2:
            begin
                state_next = ST_NX3;
            end
            ST_NX3, ST_NOWORD:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // table memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[mem_waddr] <= mem_wdata;
        rdata_reg <= table_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= 1'b0;
            mixk_reg      <= 32'd0;
            accum_reg     <= 32'd0;
            d_reg         <= 8'd0;
            step_reg      <= 8'hFF;
            remain_reg    <= 8'd0;
            rsp_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == ST_FOLD) || (state_reg == ST_APPLY);
            if (cfg_write)
                mode_reg <= cfg_data;
            if (out_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_acc && (req.command == CMD_START))
                    begin
                        d_reg      <= 8'd0;
                        step_reg   <= 8'hFF;
                        remain_reg <= req.block_length;
                    end
                end
                ST_FILL_WR:
                begin
                    if ((cnt_reg == IDX_LAST) && !start_mode_reg)
                    begin
                        mixk_reg  <= key_reg;
                        accum_reg <= key_reg;
                    end
                end
                ST_APPLY_END:
                begin
                    mixk_reg  <= kacc_reg;
                    accum_reg <= kacc_reg;
                end
                ST_NX2:
                begin
                    accum_reg <= a_new;
                end
                ST_NX3:
                begin
                    if (out_free)
                    begin
                        d_reg      <= w_c[7:0];
                        step_reg   <= step_reg - 8'd1;
                        remain_reg <= remain_reg - 8'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (out_load)
        begin
            if (state_reg == ST_NX3)
            begin
                word_reg   <= w_c;
                last_reg   <= (remain_reg == 8'd1);
                noword_reg <= 1'b0;
            end
            else
            begin
                word_reg   <= 32'd0;
                last_reg   <= 1'b0;
                noword_reg <= 1'b1;
            end
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (req_acc && (req.command == CMD_START))
                begin
                    key_reg        <= req.key;
                    start_mode_reg <= mode_reg;
                    cnt_reg        <= 8'd0;
                    nc_reg         <= 32'd0;
                    hacc_reg       <= 32'd0;
                    kacc_reg       <= 32'd0;
                end
            end
            ST_KT3:
            begin
                kt_reg <= kt3_m;
            end
            ST_FILL_WR:
            begin
                cnt_reg <= cnt_reg + 8'd1;
                nc_reg  <= nc_reg + C_KEY_MUL;
            end
            ST_FOLD, ST_FOLD_END:
            begin
                if (state_reg == ST_FOLD)
                begin
                    cnt_reg    <= cnt_reg + 8'd1;
                    rd_idx_reg <= cnt_reg;
                end
                if (rd_pend_reg)
                begin
                    if (rd_idx_reg[4:0] == 5'h1F)
                    begin
                        h_reg[rd_idx_reg[7:5]] <= fold_x;
                        kacc_reg <= kacc_reg ^ (fold_x << rd_idx_reg[7:5]);
                        hacc_reg <= 32'd0;
                    end
                    else
                    begin
                        hacc_reg <= fold_x;
                    end
                end
            end
            ST_APPLY:
            begin
                cnt_reg    <= cnt_reg + 8'd1;
                rd_idx_reg <= cnt_reg;
            end
            ST_NX1:
            begin
                t6_reg <= rdata_reg;
            end
            ST_NX2:
            begin
                o_reg <= o_c;
            end
            default:
            begin
            end
        endcase
    end

endmodule
